// ----- rtl/lsmpq_pkg.sv -----
// ----------------------------------------------------------------------------
// lsmpq_pkg
// Shared types for the linear scan minimum priority queue: operation and
// status codes and the command and status bundles that join the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lsmpq_pkg;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic    push;
		logic    scan_clr;
		logic    scan_rd;
		logic    last_rd;
		logic    move;
		logic    load_out;
		logic    sel_best;
		status_t res_status;
	} lsmpq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic scan_end;
		logic out_free;
	} lsmpq_sts_t;

endpackage

// ----- rtl/lsmpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsmpq_ctrl
// Controller state machine. Accepts one beat at a time, steps the datapath
// through the push, the pop scan, the refill of the freed slot and the
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module lsmpq_ctrl
	import lsmpq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  lsmpq_sts_t sts,
	output lsmpq_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_MOVE,
		S_EMIT
	} state_t;

	state_t  state_q;
	state_t  state_nxt;
	status_t status_q;
	status_t status_nxt;
	logic    popok_q;
	logic    popok_nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.res_status = status_q;
		state_nxt      = state_q;
		status_nxt     = status_q;
		popok_nxt      = popok_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					popok_nxt  = 1'b0;
					status_nxt = ST_OK;
					state_nxt  = S_EMIT;
					if (operation == OP_PUSH) begin
						if (sts.full) begin
							status_nxt = ST_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end else begin
						if (sts.empty) begin
							status_nxt = ST_EMPTY;
						end else begin
							cmd.scan_clr = 1'b1;
							popok_nxt    = 1'b1;
							state_nxt    = S_SCAN;
						end
					end
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_end) begin
					state_nxt = S_LAST;
				end
			end
			S_LAST: begin
				cmd.last_rd = 1'b1;
				state_nxt   = S_MOVE;
			end
			S_MOVE: begin
				cmd.move  = 1'b1;
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				cmd.sel_best = popok_q;
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
			popok_q  <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			status_q <= status_nxt;
			popok_q  <= popok_nxt;
		end
	end

endmodule

// ----- rtl/lsmpq_dpath.sv -----
// ----------------------------------------------------------------------------
// lsmpq_dpath
// Datapath: the entry memory, the fill count, the scan address counter, the
// minimum tracker fed by the registered read port and the output register.
// ----------------------------------------------------------------------------
module lsmpq_dpath
	import lsmpq_pkg::*;
#(
	parameter int DEPTH       = 256,
	parameter int KEY_BITS    = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lsmpq_cmd_t                 cmd,
	output lsmpq_sts_t                 sts,
	input  logic [KEY_BITS-1:0]        key,
	input  logic [HANDLE_BITS-1:0]     handle,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [KEY_BITS-1:0]        out_key,
	output logic [HANDLE_BITS-1:0]     out_handle,
	output logic [1:0]                 status,
	output logic [$clog2(DEPTH+1)-1:0] occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = KEY_BITS + HANDLE_BITS;

	logic [WW-1:0]          mem [DEPTH];
	logic [CW-1:0]          count_q;
	logic [AW-1:0]          scan_idx_q;
	logic [AW-1:0]          last_addr;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic [WW-1:0]          wr_word;
	logic                   wr_en;
	logic [WW-1:0]          rd_word_s1;
	logic [AW-1:0]          rd_idx_s1;
	logic                   rd_vld_s1;
	logic [KEY_BITS-1:0]    rd_key;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic [KEY_BITS-1:0]    best_key_q;
	logic [HANDLE_BITS-1:0] best_handle_q;
	logic [AW-1:0]          best_idx_q;
	logic                   out_valid_q;
	logic [KEY_BITS-1:0]    out_key_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	status_t                out_status_q;
	logic [CW-1:0]          out_occ_q;
	logic [CW-1:0]          last_cnt;

	assign last_cnt  = count_q - CW'(1);
	assign last_addr = last_cnt[AW-1:0];
	assign rd_addr   = cmd.last_rd ? last_addr : scan_idx_q;
	assign wr_en     = cmd.push | cmd.move;
	assign wr_addr   = cmd.move ? best_idx_q : count_q[AW-1:0];
	assign wr_word   = cmd.move ? rd_word_s1 : {key, handle};
	assign rd_key    = rd_word_s1[WW-1 -: KEY_BITS];
	assign rd_handle = rd_word_s1[HANDLE_BITS-1:0];

	assign sts.empty    = (count_q == '0);
	assign sts.full     = (count_q == CW'(DEPTH));
	assign sts.scan_end = (scan_idx_q == last_addr);
	assign sts.out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		rd_word_s1 <= mem[rd_addr];
		rd_idx_s1  <= scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.move) begin
				count_q <= last_cnt;
			end
			if (cmd.scan_clr) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && ((rd_idx_s1 == '0) || (rd_key < best_key_q))) begin
			best_key_q    <= rd_key;
			best_handle_q <= rd_handle;
			best_idx_q    <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_key_q    <= cmd.sel_best ? best_key_q : '0;
			out_handle_q <= cmd.sel_best ? best_handle_q : '0;
			out_status_q <= cmd.res_status;
			out_occ_q    <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_key    = out_key_q;
	assign out_handle = out_handle_q;
	assign status     = out_status_q;
	assign occupancy  = out_occ_q;

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Fill count exceeds the table depth.");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> count_q != '0)
		else $error("Push did not leave the table occupied.");

	a_move_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.move |-> (count_q != '0) && !rd_vld_s1)
		else $error("Refill issued on an empty table or during the scan.");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("Output register overwritten before its beat was taken.");
`endif

endmodule

// ----- rtl/linear_scan_min_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// linear_scan_min_priority_queue_unit
// Minimum priority queue held as an unsorted table of key and handle entries.
// A push appends at the end; a pop scans all occupied entries for the lowest
// key (earliest slot on ties) and refills the freed slot with the last entry.
//
// Channel  Signals                                      Direction
// input    in_valid, in_ready, operation, key, handle   beat into the queue
// output   out_valid, out_ready, out_key, out_handle,   result beat
//          status, occupancy
//
// A push, a push on full and a pop on empty go straight from idle to emit.
// A pop passes the scan, last-entry read, refill and emit states; the scan
// reads one entry per cycle through the single read port of the entry memory.
// Reset clears the fill count and the control state; the entry memory is
// not cleared, only written slots are ever read.
// A stalled output holds the controller until the result register is free.
// ----------------------------------------------------------------------------
module linear_scan_min_priority_queue_unit
	import lsmpq_pkg::*;
#(
	parameter int DEPTH       = 256,
	parameter int KEY_BITS    = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic [KEY_BITS-1:0]        key,
	input  logic [HANDLE_BITS-1:0]     handle,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [KEY_BITS-1:0]        out_key,
	output logic [HANDLE_BITS-1:0]     out_handle,
	output logic [1:0]                 status,
	output logic [$clog2(DEPTH+1)-1:0] occupancy
);

	lsmpq_cmd_t cmd;
	lsmpq_sts_t sts;

	lsmpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	lsmpq_dpath #(
		.DEPTH       (DEPTH),
		.KEY_BITS    (KEY_BITS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.key        (key),
		.handle     (handle),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_key    (out_key),
		.out_handle (out_handle),
		.status     (status),
		.occupancy  (occupancy)
	);

endmodule

// ----- test/tb_linear_scan_min_priority_queue_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_scan_min_priority_queue_unit
// Self-checking bench for the linear scan minimum priority queue. A short
// table of directed beats covers empty pops, extreme keys and handles and
// ties on equal keys. Random bursts of pushes and pops follow, together with
// full fill and drain runs that reach the full and empty limits. Every
// result beat is checked against its directed row or a shadow table kept in
// the bench; the input idles and the output stalls at random in the phases.
// ----------------------------------------------------------------------------
module tb_linear_scan_min_priority_queue_unit;
	import lsmpq_pkg::*;

	localparam int DEPTH       = 256;
	localparam int KEY_BITS    = 16;
	localparam int HANDLE_BITS = 16;
	localparam int OCC_BITS    = $clog2(DEPTH + 1);
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_BEATS = 450;
	localparam int DRAIN_WAIT  = DEPTH + 40;

	typedef struct packed {
		logic [KEY_BITS-1:0]    k;
		logic [HANDLE_BITS-1:0] h;
		status_t                st;
		logic [OCC_BITS-1:0]    occ;
	} pq_result_t;

	typedef struct {
		op_t                    op;
		logic [KEY_BITS-1:0]    k;
		logic [HANDLE_BITS-1:0] h;
		bit                     typed;
		pq_result_t             want;
	} stim_row_t;

	localparam pq_result_t NO_TYPED = '{'0, '0, ST_OK, '0};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   operation = 1'b0;
	logic [KEY_BITS-1:0]    key = '0;
	logic [HANDLE_BITS-1:0] handle = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [KEY_BITS-1:0]    out_key;
	logic [HANDLE_BITS-1:0] out_handle;
	logic [1:0]             status;
	logic [OCC_BITS-1:0]    occupancy;

	logic [KEY_BITS-1:0]    shadow_key [DEPTH];
	logic [HANDLE_BITS-1:0] shadow_handle [DEPTH];
	int                     shadow_count = 0;

	pq_result_t awaited_results [$];
	stim_row_t  directed_rows [18];
	int         in_idle_pct = 0;
	int         out_stall_pct = 0;
	int         error_count = 0;
	int         beats_sent = 0;
	int         cycle_count = 0;

	linear_scan_min_priority_queue_unit #(
		.DEPTH(DEPTH),
		.KEY_BITS(KEY_BITS),
		.HANDLE_BITS(HANDLE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.key(key),
		.handle(handle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_key(out_key),
		.out_handle(out_handle),
		.status(status),
		.occupancy(occupancy)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < 100) begin
			$display("error: %s got %0h want %0h at cycle %0d", what, got, want, cycle_count);
		end
		error_count++;
	endtask

	task automatic predict_access(input op_t op, input logic [KEY_BITS-1:0] k,
			input logic [HANDLE_BITS-1:0] h, output pq_result_t res);
		int best;
		res = NO_TYPED;
		if (op == OP_PUSH) begin
			if (shadow_count >= DEPTH) begin
				res.st = ST_FULL;
			end else begin
				shadow_key[shadow_count] = k;
				shadow_handle[shadow_count] = h;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			res.st = ST_EMPTY;
		end else begin
			best = 0;
			for (int i = 1; i < shadow_count; i++) begin
				if (shadow_key[i] < shadow_key[best]) begin
					best = i;
				end
			end
			res.k = shadow_key[best];
			res.h = shadow_handle[best];
			shadow_key[best] = shadow_key[shadow_count - 1];
			shadow_handle[best] = shadow_handle[shadow_count - 1];
			shadow_count--;
		end
		res.occ = shadow_count[OCC_BITS-1:0];
	endtask

	task automatic send_beat(input op_t op, input logic [KEY_BITS-1:0] k,
			input logic [HANDLE_BITS-1:0] h, input bit typed, input pq_result_t want);
		pq_result_t predicted;
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		handle <= h;
		@(posedge clk);
		while (in_ready !== 1'b1) begin
			@(posedge clk);
		end
		predict_access(op, k, h, predicted);
		awaited_results.push_back(typed ? want : predicted);
		beats_sent++;
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key(input int mode);
		case (mode)
			0: pick_key = KEY_BITS'($urandom_range(65535));
			1: pick_key = KEY_BITS'($urandom_range(7));
			2: pick_key = $urandom_range(1) ? '1 : '0;
			default: pick_key = '1 - KEY_BITS'($urandom_range(7));
		endcase
	endfunction

	task automatic fill_and_drain(input int mode);
		while (shadow_count < DEPTH) begin
			send_beat(OP_PUSH, pick_key(mode), HANDLE_BITS'($urandom_range(65535)), 1'b0,
				NO_TYPED);
		end
		repeat (3) begin
			send_beat(OP_PUSH, pick_key(0), HANDLE_BITS'($urandom_range(65535)), 1'b0,
				NO_TYPED);
		end
		while (shadow_count > 0) begin
			send_beat(OP_POP, pick_key(0), HANDLE_BITS'($urandom_range(65535)), 1'b0,
				NO_TYPED);
		end
		send_beat(OP_POP, pick_key(0), HANDLE_BITS'($urandom_range(65535)), 1'b0, NO_TYPED);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		pq_result_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result beat with nothing awaited, out_key", out_key, '0);
			end else begin
				want = awaited_results.pop_front();
				if (out_key !== want.k) begin
					report_mismatch("out_key", out_key, want.k);
				end
				if (out_handle !== want.h) begin
					report_mismatch("out_handle", out_handle, want.h);
				end
				if (status !== want.st) begin
					report_mismatch("status", status, want.st);
				end
				if (occupancy !== want.occ) begin
					report_mismatch("occupancy", occupancy, want.occ);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("linear_scan_min_priority_queue_unit: mismatch");
			$finish;
		end
	end

	initial begin
		int in_pcts [4];
		int out_pcts [4];
		int phase_end;
		int burst_len;
		int push_pct;
		int key_mode;
		op_t op;

		in_pcts = '{0, 74, 0, 18};
		out_pcts = '{0, 0, 74, 18};
		directed_rows = '{
			'{OP_POP,  16'h0000, 16'h0000, 1'b1, '{16'h0, 16'h0, ST_EMPTY, 9'd0}},
			'{OP_PUSH, 16'hFFFF, 16'h0000, 1'b1, '{16'h0, 16'h0, ST_OK, 9'd1}},
			'{OP_PUSH, 16'h0000, 16'hFFFF, 1'b1, '{16'h0, 16'h0, ST_OK, 9'd2}},
			'{OP_PUSH, 16'h8000, 16'h5555, 1'b1, '{16'h0, 16'h0, ST_OK, 9'd3}},
			'{OP_PUSH, 16'h0000, 16'hAAAA, 1'b1, '{16'h0, 16'h0, ST_OK, 9'd4}},
			'{OP_PUSH, 16'h7FFF, 16'h1234, 1'b1, '{16'h0, 16'h0, ST_OK, 9'd5}},
			'{OP_POP,  16'hFFFF, 16'hFFFF, 1'b0, NO_TYPED},
			'{OP_POP,  16'h0000, 16'h0000, 1'b0, NO_TYPED},
			'{OP_POP,  16'h0000, 16'h0000, 1'b0, NO_TYPED},
			'{OP_POP,  16'h0000, 16'h0000, 1'b0, NO_TYPED},
			'{OP_POP,  16'h0000, 16'h0000, 1'b0, NO_TYPED},
			'{OP_POP,  16'hFFFF, 16'hFFFF, 1'b1, '{16'h0, 16'h0, ST_EMPTY, 9'd0}},
			'{OP_PUSH, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0, 16'h0, ST_OK, 9'd1}},
			'{OP_PUSH, 16'hFFFF, 16'h0001, 1'b1, '{16'h0, 16'h0, ST_OK, 9'd2}},
			'{OP_POP,  16'h0000, 16'h0000, 1'b0, NO_TYPED},
			'{OP_POP,  16'h0000, 16'h0000, 1'b0, NO_TYPED},
			'{OP_PUSH, 16'h0000, 16'h0000, 1'b1, '{16'h0, 16'h0, ST_OK, 9'd1}},
			'{OP_POP,  16'h0000, 16'h0000, 1'b0, NO_TYPED}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].op, directed_rows[i].k, directed_rows[i].h,
				directed_rows[i].typed, directed_rows[i].want);
		end

		for (int phase = 0; phase < 4; phase++) begin
			in_idle_pct = in_pcts[phase];
			out_stall_pct = out_pcts[phase];
			phase_end = beats_sent + PHASE_BEATS;
			if (phase == 0 || phase == 2) begin
				fill_and_drain(phase == 0 ? 0 : 1);
			end
			while (beats_sent < phase_end) begin
				burst_len = $urandom_range(40, 10);
				push_pct = $urandom_range(75, 25);
				key_mode = $urandom_range(3);
				repeat (burst_len) begin
					op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
					send_beat(op, pick_key(key_mode), HANDLE_BITS'($urandom_range(65535)),
						1'b0, NO_TYPED);
				end
			end
		end
		in_valid <= 1'b0;

		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0) begin
			$display("linear_scan_min_priority_queue_unit: match");
		end else begin
			$display("linear_scan_min_priority_queue_unit: mismatch");
		end
		$finish;
	end

endmodule
